@@ sv/mva_pkg.sv @@
// ----------------------------------------------------------------------------
// mva_pkg
// shared types and constants for the matrix-vector multiply/adjoint block
// ----------------------------------------------------------------------------
package mva_pkg;

   // default array dimensions
   localparam int MAX_ROWS_DEF = 16;
   localparam int MAX_COLS_DEF = 16;

   // field widths
   localparam int SIZE_W      = 5;
   localparam int IDX_W       = 4;
   localparam int VAL_W       = 16;
   localparam int PROD_W      = 32;
   localparam int RES_W       = 38;
   localparam int ACT_W       = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int ADDR_CALC_W = 16;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 48;

   // size register reset value before clamping
   localparam int SIZE_RESET = 16;

   // request kinds
   localparam logic [ACT_W-1:0] ACT_MAT_WR = 2'd0;
   localparam logic [ACT_W-1:0] ACT_VEC_WR = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FWD    = 2'd2;
   localparam logic [ACT_W-1:0] ACT_ADJ    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic              mat_we;
      logic              vec_we;
      logic              issue;
      logic              adj;
      logic [SIZE_W-1:0] outer;
      logic [SIZE_W-1:0] inner;
      logic              first;
      logic              last_inner;
      logic              last_outer;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic stall;
      logic pipe_busy;
   } status_type;

   // flags that travel with each multiply-accumulate step
   typedef struct packed {
      logic             first;
      logic             last_inner;
      logic             last_outer;
      logic [IDX_W-1:0] idx;
   } tag_type;

endpackage

@@ sv/matrix_vector_multiply_adjoint_top.sv @@
// ----------------------------------------------------------------------------
// matrix_vector_multiply_adjoint_top
// dense matrix times vector, forward (A*x) or adjoint (A-transpose*y)
// ----------------------------------------------------------------------------
// loads (matrix or vector writes) are accepted back to back
// a product request closes the request side while rows*cols multiply-accumulate
// steps issue and the pipe drains; a held result freezes the pipe
// one result per outer index, each summing inner steps (inner is cols forward,
// rows adjoint); a held result holds off the results behind it
// reset clears sequencer, pipe valids and sizes (16, capped); memories not cleared
module matrix_vector_multiply_adjoint_top #(
   parameter int MAX_ROWS = mva_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = mva_pkg::MAX_COLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mva_pkg::REQ_DATA_W-1:0]      req_tdata,   // row_index, col_index, value
   input  logic [mva_pkg::ACT_W-1:0]           req_tuser,   // action
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mva_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // result_value, result_index
   output logic                                rsp_tlast,
   // size registers
   input  logic                                csr_we,
   input  logic [mva_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mva_pkg::SIZE_W-1:0]          csr_wdata
);

   // vector store serves both x (cols long) and y (rows long)
   localparam int VEC_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

   localparam int ROW_LO = 0;
   localparam int COL_LO = ROW_LO + mva_pkg::IDX_W;
   localparam int VAL_LO = COL_LO + mva_pkg::IDX_W;

   mva_pkg::cmd_type                  cmd;
   mva_pkg::status_type               status;
   logic [mva_pkg::IDX_W-1:0]         req_row, req_col;
   logic signed [mva_pkg::VAL_W-1:0]  req_value;
   logic signed [mva_pkg::RES_W-1:0]  rsp_value;
   logic [mva_pkg::IDX_W-1:0]         rsp_index;

   // unpack request fields
   assign req_row   = req_tdata[ROW_LO +: mva_pkg::IDX_W];
   assign req_col   = req_tdata[COL_LO +: mva_pkg::IDX_W];
   assign req_value = req_tdata[VAL_LO +: mva_pkg::VAL_W];

   // pack result fields, zero padded to whole bytes
   assign rsp_tdata = {{(mva_pkg::RSP_DATA_W - mva_pkg::RES_W - mva_pkg::IDX_W){1'b0}},
                       rsp_index, rsp_value};

   // sequencer: decodes requests, owns sizes, walks the row/column loops
   mva_ctrl #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .VEC_DEPTH (VEC_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_row    (req_row),
      .req_col    (req_col),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

   // memories and the multiply-accumulate pipe with its result register
   mva_datapath #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .VEC_DEPTH (VEC_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_index  (rsp_index),
      .rsp_last   (rsp_tlast)
   );

   // a product request closes the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[1]) |=> !req_tready)
      else $error("request side open after product request");

   // no request taken while steps are still in the pipe
   assert property (@(posedge clock) disable iff (reset)
      status.pipe_busy |-> !req_tready)
      else $error("request accepted while product in flight");

   // no step issued while the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !status.stall)
      else $error("step issued during result stall");

endmodule

@@ sv/mva_ctrl.sv @@
// ----------------------------------------------------------------------------
// mva_ctrl
// size registers, request decode and the loop sequencer for products
// ----------------------------------------------------------------------------
module mva_ctrl #(
   parameter int MAX_ROWS  = mva_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = mva_pkg::MAX_COLS_DEF,
   parameter int VEC_DEPTH = mva_pkg::MAX_ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mva_pkg::ACT_W-1:0]      req_action,
   input  logic [mva_pkg::IDX_W-1:0]      req_row,
   input  logic [mva_pkg::IDX_W-1:0]      req_col,
   input  logic                           csr_we,
   input  logic [mva_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mva_pkg::SIZE_W-1:0]     csr_wdata,
   output mva_pkg::cmd_type               cmd,
   input  mva_pkg::status_type            status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam int ROWS_RST = (MAX_ROWS < mva_pkg::SIZE_RESET) ? MAX_ROWS : mva_pkg::SIZE_RESET;
   localparam int COLS_RST = (MAX_COLS < mva_pkg::SIZE_RESET) ? MAX_COLS : mva_pkg::SIZE_RESET;

   function automatic logic [mva_pkg::SIZE_W-1:0] clamp_size(
      input logic [mva_pkg::SIZE_W-1:0] v,
      input int                         max_v
   );
      logic [mva_pkg::SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = mva_pkg::SIZE_W'(1);
      end else if (int'(v) > max_v) begin
         r = mva_pkg::SIZE_W'(max_v);
      end
      return r;
   endfunction

   logic [1:0]                  state_ff, state_in;
   logic [mva_pkg::SIZE_W-1:0]  rows_ff, rows_in;
   logic [mva_pkg::SIZE_W-1:0]  cols_ff, cols_in;
   logic [mva_pkg::SIZE_W-1:0]  outer_ff, outer_in;
   logic [mva_pkg::SIZE_W-1:0]  inner_ff, inner_in;
   logic                        adj_ff, adj_in;
   logic [mva_pkg::SIZE_W-1:0]  n_inner, n_outer, vec_len;
   logic                        accept, last_inner, last_outer, issue;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign n_inner    = adj_ff ? rows_ff : cols_ff;
   assign n_outer    = adj_ff ? cols_ff : rows_ff;
   assign vec_len    = (rows_ff > cols_ff) ? rows_ff : cols_ff;
   assign last_inner = (inner_ff == n_inner - mva_pkg::SIZE_W'(1));
   assign last_outer = (outer_ff == n_outer - mva_pkg::SIZE_W'(1));
   assign issue      = (state_ff == ST_RUN) && !status.stall;

   always_comb begin
      cmd.mat_we     = accept && (req_action == mva_pkg::ACT_MAT_WR) &&
                       (mva_pkg::SIZE_W'(req_row) < rows_ff) &&
                       (mva_pkg::SIZE_W'(req_col) < cols_ff);
      cmd.vec_we     = accept && (req_action == mva_pkg::ACT_VEC_WR) &&
                       (mva_pkg::SIZE_W'(req_col) < vec_len) &&
                       (int'(req_col) < VEC_DEPTH);
      cmd.issue      = issue;
      cmd.adj        = adj_ff;
      cmd.outer      = outer_ff;
      cmd.inner      = inner_ff;
      cmd.first      = (inner_ff == '0);
      cmd.last_inner = last_inner;
      cmd.last_outer = last_outer;
   end

   always_comb begin
      state_in = state_ff;
      outer_in = outer_ff;
      inner_in = inner_ff;
      adj_in   = adj_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == mva_pkg::ACT_FWD || req_action == mva_pkg::ACT_ADJ)) begin
               state_in = ST_RUN;
               adj_in   = (req_action == mva_pkg::ACT_ADJ);
               outer_in = '0;
               inner_in = '0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (last_inner) begin
                  inner_in = '0;
                  if (last_outer) begin
                     state_in = ST_DRAIN;
                  end else begin
                     outer_in = outer_ff + mva_pkg::SIZE_W'(1);
                  end
               end else begin
                  inner_in = inner_ff + mva_pkg::SIZE_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we && csr_index == mva_pkg::CSR_ROWS) begin
         rows_in = clamp_size(csr_wdata, MAX_ROWS);
      end
      if (csr_we && csr_index == mva_pkg::CSR_COLS) begin
         cols_in = clamp_size(csr_wdata, MAX_COLS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= mva_pkg::SIZE_W'(ROWS_RST);
         cols_ff  <= mva_pkg::SIZE_W'(COLS_RST);
         outer_ff <= '0;
         inner_ff <= '0;
         adj_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
         adj_ff   <= adj_in;
      end
   end

endmodule

@@ sv/mva_datapath.sv @@
// ----------------------------------------------------------------------------
// mva_datapath
// matrix and vector memories, multiply-accumulate pipe and result register
// ----------------------------------------------------------------------------
module mva_datapath #(
   parameter int MAX_ROWS  = mva_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = mva_pkg::MAX_COLS_DEF,
   parameter int VEC_DEPTH = mva_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mva_pkg::cmd_type                    cmd,
   output mva_pkg::status_type                 status,
   input  logic [mva_pkg::IDX_W-1:0]           req_row,
   input  logic [mva_pkg::IDX_W-1:0]           req_col,
   input  logic signed [mva_pkg::VAL_W-1:0]    req_value,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [mva_pkg::RES_W-1:0]    rsp_value,
   output logic [mva_pkg::IDX_W-1:0]           rsp_index,
   output logic                                rsp_last
);

   localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int VEC_AW    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
   localparam int AW        = mva_pkg::ADDR_CALC_W;

   logic signed [mva_pkg::VAL_W-1:0] mat_mem [MAT_DEPTH];
   logic signed [mva_pkg::VAL_W-1:0] vec_mem [VEC_DEPTH];

   logic [AW-1:0]                    mat_wfull, mat_rfull, vec_wfull, vec_rfull;
   logic [mva_pkg::SIZE_W-1:0]       row_sel, col_sel;
   logic                             stall, en;

   logic signed [mva_pkg::VAL_W-1:0]  m_rd_ff, v_rd_ff;
   logic                              s1_valid_ff, s2_valid_ff;
   mva_pkg::tag_type                  s1_tag_ff, s2_tag_ff, s0_tag;
   logic signed [mva_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [mva_pkg::RES_W-1:0]  acc_ff, sum_in;
   logic                              out_valid_ff;
   logic signed [mva_pkg::RES_W-1:0]  out_value_ff;
   logic [mva_pkg::IDX_W-1:0]         out_index_ff;
   logic                              out_last_ff;

   assign stall = out_valid_ff && !rsp_tready;
   assign en    = !stall;

   assign row_sel   = cmd.adj ? cmd.inner : cmd.outer;
   assign col_sel   = cmd.adj ? cmd.outer : cmd.inner;
   assign mat_wfull = AW'(req_row) * AW'(MAX_COLS) + AW'(req_col);
   assign mat_rfull = AW'(row_sel) * AW'(MAX_COLS) + AW'(col_sel);
   assign vec_wfull = AW'(req_col);
   assign vec_rfull = AW'(cmd.inner);

   always_comb begin
      s0_tag.first      = cmd.first;
      s0_tag.last_inner = cmd.last_inner;
      s0_tag.last_outer = cmd.last_outer;
      s0_tag.idx        = cmd.outer[mva_pkg::IDX_W-1:0];
   end

   // memories, read data registered
   always_ff @(posedge clock) begin
      if (cmd.mat_we) begin
         mat_mem[mat_wfull[MAT_AW-1:0]] <= req_value;
      end
      if (en) begin
         m_rd_ff <= mat_mem[mat_rfull[MAT_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vec_we) begin
         vec_mem[vec_wfull[VEC_AW-1:0]] <= req_value;
      end
      if (en) begin
         v_rd_ff <= vec_mem[vec_rfull[VEC_AW-1:0]];
      end
   end

   assign prod_in = m_rd_ff * v_rd_ff;
   assign sum_in  = (s2_tag_ff.first ? mva_pkg::RES_W'(0) : acc_ff) + mva_pkg::RES_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff <= s0_tag;
         s2_tag_ff <= s1_tag_ff;
         prod_ff   <= prod_in;
         if (s2_valid_ff) begin
            acc_ff <= sum_in;
         end
         if (s2_valid_ff && s2_tag_ff.last_inner) begin
            out_value_ff <= sum_in;
            out_index_ff <= s2_tag_ff.idx;
            out_last_ff  <= s2_tag_ff.last_outer;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff && s2_tag_ff.last_inner;
      end
   end

   assign status.stall     = stall;
   assign status.pipe_busy = s1_valid_ff || s2_valid_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_index  = out_index_ff;
   assign rsp_last   = out_last_ff;

endmodule
